### hdl/bec_pkg.sv
package bec_pkg;

  localparam int VTX_W = 10;
  localparam int GRP_W = 4;
  localparam int OP_W  = 2;
  localparam int NG_W  = 5;
  localparam int STS_W = 2;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_GROUPS_DEF   = 16;
  localparam int COUNT_BITS_DEF   = 24;

  localparam logic [NG_W-1:0] NUM_GROUPS_RST = 5'd2;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_ADD   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_SAT   = 2'd2
  } status_t;

  // which cell address drives the count memory read port
  typedef enum logic [1:0] {
    SEL_ROWCOL = 2'd0,
    SEL_COLROW = 2'd1,
    SEL_CELL   = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    tbl_we;
    rd_sel_t rd_sel;
    logic    cnt_we;
    logic    wr_zero;
    logic    sweep_inc;
    logic    total_inc;
    logic    total_clr;
    logic    hold_raw;
    logic    emit;
    logic    emit_read;
    status_t emit_sts;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic set_ok;
    logic vtx_ok;
    logic pair_ok;
    logic rc_ok;
    logic sat;
    logic sweep_last;
  } dp_sts_t;

endpackage

### hdl/block_edge_count_accumulator.sv
// Group edge-count accumulator. An item is taken when start is high and busy is low, and
// its one result shows on the out_ ports for a single cycle with out_strobe. It must be
// captured then, as the block cannot be stalled. out_strobe is registered from the state
// that ends the item: DECODE for set membership, clear and any item rejected for range,
// ADD_WR for an add entry and RD_B for a read. An add entry passes LOOKUP and a read
// RD_A first, set by the registered membership lookup and the single read port of the
// count memory (read, then write or second read). A clear keeps busy high while every
// cell of the count memory is zeroed, one cell a cycle, and the same pass runs after reset
// before the first item is taken. num_groups may be written at any time busy is low or a
// clear pass is running.
module block_edge_count_accumulator #(
  parameter int MAX_VERTICES = bec_pkg::MAX_VERTICES_DEF,
  parameter int MAX_GROUPS   = bec_pkg::MAX_GROUPS_DEF,
  parameter int COUNT_BITS   = bec_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bec_pkg::NG_W-1:0]      cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [bec_pkg::OP_W-1:0]      in_op,
  input  logic [bec_pkg::VTX_W-1:0]     in_vertex,
  input  logic [bec_pkg::VTX_W-1:0]     in_neighbour,
  input  logic [bec_pkg::GRP_W-1:0]     in_group,
  input  logic [bec_pkg::GRP_W-1:0]     in_row_group,
  input  logic [bec_pkg::GRP_W-1:0]     in_col_group,
  output logic                          out_strobe,
  output logic [COUNT_BITS-1:0]         out_raw_count,
  output logic [COUNT_BITS-2:0]         out_half_count,
  output logic [COUNT_BITS-2:0]         out_edge_total,
  output logic [bec_pkg::STS_W-1:0]     out_status
);
  import bec_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bec_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  bec_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_GROUPS   (MAX_GROUPS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_op          (in_op),
    .in_vertex      (in_vertex),
    .in_neighbour   (in_neighbour),
    .in_group       (in_group),
    .in_row_group   (in_row_group),
    .in_col_group   (in_col_group),
    .cmd            (cmd),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_raw_count  (out_raw_count),
    .out_half_count (out_half_count),
    .out_edge_total (out_edge_total),
    .out_status     (out_status)
  );

  // a taken item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after an item was taken");

  // every item needs a decode cycle, so results never come on consecutive cycles
  a_no_back_to_back_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on consecutive cycles");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a busy cycle before it");

  // only a good read carries cell data
  a_error_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != STS_OK)) |-> ((out_raw_count == '0) && (out_half_count == '0)))
    else $error("counts nonzero on an error result");

endmodule

### hdl/bec_ctrl.sv
module bec_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bec_pkg::dp_sts_t  sts,
  output bec_pkg::dp_cmd_t  cmd
);
  import bec_pkg::*;

  typedef enum logic [6:0] {
    ST_SWEEP  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_DECODE = 7'b0000100,
    ST_LOOKUP = 7'b0001000,
    ST_ADD_WR = 7'b0010000,
    ST_RD_A   = 7'b0100000,
    ST_RD_B   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = SEL_ROWCOL;
    cmd.emit_sts  = STS_OK;
    case (state_r)
      ST_SWEEP: begin
        cmd.cnt_we    = 1'b1;
        cmd.wr_zero   = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.op)
          OP_SET: begin
            cmd.tbl_we   = sts.set_ok && sts.vtx_ok;
            cmd.emit     = 1'b1;
            cmd.emit_sts = sts.set_ok ? STS_OK : STS_RANGE;
            state_nxt    = ST_IDLE;
          end
          OP_ADD: begin
            if (sts.pair_ok) begin
              state_nxt = ST_LOOKUP;
            end else begin
              cmd.emit  = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
          OP_READ: begin
            if (sts.rc_ok) begin
              cmd.rd_sel = SEL_ROWCOL;
              state_nxt  = ST_RD_A;
            end else begin
              cmd.emit     = 1'b1;
              cmd.emit_sts = STS_RANGE;
              state_nxt    = ST_IDLE;
            end
          end
          OP_CLEAR: begin
            cmd.total_clr = 1'b1;
            cmd.emit      = 1'b1;
            state_nxt     = ST_SWEEP;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_LOOKUP: begin
        cmd.rd_sel = SEL_CELL;
        state_nxt  = ST_ADD_WR;
      end
      ST_ADD_WR: begin
        cmd.emit = 1'b1;
        if (sts.sat) begin
          cmd.emit_sts = STS_SAT;
        end else begin
          cmd.cnt_we    = 1'b1;
          cmd.total_inc = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_RD_A: begin
        cmd.hold_raw = 1'b1;
        cmd.rd_sel   = SEL_COLROW;
        state_nxt    = ST_RD_B;
      end
      ST_RD_B: begin
        cmd.emit      = 1'b1;
        cmd.emit_read = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_SWEEP;
    endcase
  end

endmodule

### hdl/bec_datapath.sv
module bec_datapath #(
  parameter int MAX_VERTICES = bec_pkg::MAX_VERTICES_DEF,
  parameter int MAX_GROUPS   = bec_pkg::MAX_GROUPS_DEF,
  parameter int COUNT_BITS   = bec_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bec_pkg::NG_W-1:0]      cfg_wdata,
  input  logic [bec_pkg::OP_W-1:0]      in_op,
  input  logic [bec_pkg::VTX_W-1:0]     in_vertex,
  input  logic [bec_pkg::VTX_W-1:0]     in_neighbour,
  input  logic [bec_pkg::GRP_W-1:0]     in_group,
  input  logic [bec_pkg::GRP_W-1:0]     in_row_group,
  input  logic [bec_pkg::GRP_W-1:0]     in_col_group,
  input  bec_pkg::dp_cmd_t              cmd,
  output bec_pkg::dp_sts_t              sts,
  output logic                          out_strobe,
  output logic [COUNT_BITS-1:0]         out_raw_count,
  output logic [COUNT_BITS-2:0]         out_half_count,
  output logic [COUNT_BITS-2:0]         out_edge_total,
  output logic [bec_pkg::STS_W-1:0]     out_status
);
  import bec_pkg::*;

  localparam int VA_W   = $clog2(MAX_VERTICES);
  localparam int CELLS  = MAX_GROUPS * MAX_GROUPS;
  localparam int CELL_W = $clog2(CELLS);

  logic [NG_W-1:0]       num_groups_r;
  logic [OP_W-1:0]       op_r;
  logic [VTX_W-1:0]      vertex_r, neighbour_r;
  logic [GRP_W-1:0]      group_r, row_r, col_r;

  logic [GRP_W-1:0]      tbl_mem [MAX_VERTICES];
  logic [GRP_W-1:0]      tbl_a_r, tbl_b_r;

  logic [COUNT_BITS-1:0] cnt_mem [CELLS];
  logic [COUNT_BITS-1:0] cnt_rd_r;
  logic [CELL_W-1:0]     cnt_raddr, cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic [CELL_W-1:0]     sweep_r;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [COUNT_BITS-1:0] raw_hold_r;
  logic                  strobe_r;

  function automatic logic lbl_ok(input logic [GRP_W-1:0] g, input logic [NG_W-1:0] ng);
    return (NG_W'(g) < ng) && (32'(g) < 32'(MAX_GROUPS));
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [GRP_W-1:0] r,
                                               input logic [GRP_W-1:0] c);
    return CELL_W'(r) * CELL_W'(MAX_GROUPS) + CELL_W'(c);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_groups_r <= NUM_GROUPS_RST;
    end else if (cfg_we) begin
      num_groups_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r        <= in_op;
      vertex_r    <= in_vertex;
      neighbour_r <= in_neighbour;
      group_r     <= in_group;
      row_r       <= in_row_group;
      col_r       <= in_col_group;
    end
  end

  // membership table, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.tbl_we) tbl_mem[VA_W'(vertex_r)] <= group_r;
    tbl_a_r <= tbl_mem[VA_W'(vertex_r)];
    tbl_b_r <= tbl_mem[VA_W'(neighbour_r)];
  end

  always_comb begin
    case (cmd.rd_sel)
      SEL_ROWCOL: cnt_raddr = cell_of(row_r, col_r);
      SEL_COLROW: cnt_raddr = cell_of(col_r, row_r);
      SEL_CELL:   cnt_raddr = cell_of(tbl_a_r, tbl_b_r);
      default:    cnt_raddr = cell_of(row_r, col_r);
    endcase
  end

  // table outputs still hold the item's labels while the increment is written
  assign cnt_waddr = cmd.wr_zero ? sweep_r : cell_of(tbl_a_r, tbl_b_r);
  assign cnt_wdata = cmd.wr_zero ? '0 : cnt_rd_r + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rd_r <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_inc) begin
      sweep_r <= sts.sweep_last ? '0 : sweep_r + 1'b1;
    end
  end

  always_comb begin
    total_nxt = total_r;
    if (cmd.total_clr)      total_nxt = '0;
    else if (cmd.total_inc) total_nxt = total_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_raw) raw_hold_r <= cnt_rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_raw_count  <= cmd.emit_read ? raw_hold_r : '0;
      out_half_count <= cmd.emit_read ? cnt_rd_r[COUNT_BITS-1:1] : '0;
      out_edge_total <= total_nxt[COUNT_BITS-1:1];
      out_status     <= cmd.emit_sts;
    end
  end

  assign out_strobe = strobe_r;

  assign sts.op         = op_t'(op_r);
  assign sts.set_ok     = lbl_ok(group_r, num_groups_r);
  assign sts.vtx_ok     = 32'(vertex_r) < 32'(MAX_VERTICES);
  assign sts.pair_ok    = (32'(vertex_r) < 32'(MAX_VERTICES))
                          && (32'(neighbour_r) < 32'(MAX_VERTICES));
  assign sts.rc_ok      = lbl_ok(row_r, num_groups_r) && lbl_ok(col_r, num_groups_r);
  assign sts.sat        = (cnt_rd_r == '1) || (total_r == '1);
  assign sts.sweep_last = (sweep_r == CELL_W'(CELLS - 1));

endmodule

### bench/tb_block_edge_count_accumulator.sv
module tb_block_edge_count_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import bec_pkg::*;

  localparam int CNT_W  = COUNT_BITS_DEF;
  localparam int NVTX   = MAX_VERTICES_DEF;
  localparam int NGRP   = MAX_GROUPS_DEF;
  localparam int N_RAND = 1200;

  typedef struct packed {
    op_t              op;
    logic [VTX_W-1:0] vertex;
    logic [VTX_W-1:0] neighbour;
    logic [GRP_W-1:0] group;
    logic [GRP_W-1:0] row_g;
    logic [GRP_W-1:0] col_g;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] raw;
    logic [CNT_W-2:0] half;
    logic [CNT_W-2:0] total;
    status_t          sts;
  } res_t;

  typedef enum {ROW_PREDICT, ROW_FIXED, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t       kind;
    cmd_t            cmd;
    res_t            res;
    logic [NG_W-1:0] ng;
  } drow_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [NG_W-1:0] cfg_wdata;
  logic start;
  logic busy;
  logic [OP_W-1:0] in_op;
  logic [VTX_W-1:0] in_vertex;
  logic [VTX_W-1:0] in_neighbour;
  logic [GRP_W-1:0] in_group;
  logic [GRP_W-1:0] in_row_group;
  logic [GRP_W-1:0] in_col_group;
  logic out_strobe;
  logic [CNT_W-1:0] out_raw_count;
  logic [CNT_W-2:0] out_half_count;
  logic [CNT_W-2:0] out_edge_total;
  logic [STS_W-1:0] out_status;

  // shadow state of the block
  logic [GRP_W-1:0] grp_of [NVTX];
  logic [CNT_W-1:0] cell_cnt [NGRP*NGRP];
  logic [CNT_W-1:0] entry_cnt;
  logic [NG_W-1:0]  ng_reg;

  bit               vtx_known [NVTX];
  logic [VTX_W-1:0] known_vtx [$];
  res_t             due_results [$];
  drow_t            dir_rows [$];
  int               err_cnt = 0;
  int               idle_pct = 0;

  block_edge_count_accumulator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_vertex     (in_vertex),
    .in_neighbour  (in_neighbour),
    .in_group      (in_group),
    .in_row_group  (in_row_group),
    .in_col_group  (in_col_group),
    .out_strobe    (out_strobe),
    .out_raw_count (out_raw_count),
    .out_half_count(out_half_count),
    .out_edge_total(out_edge_total),
    .out_status    (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit label_ok(logic [GRP_W-1:0] g);
    return {1'b0, g} < ng_reg;
  endfunction

  // updates the shadow state and returns the result the item should produce
  function automatic res_t tally_item(cmd_t c);
    res_t r;
    logic [2*GRP_W-1:0] cell_ix;
    r = '0;
    r.sts = STS_OK;
    case (c.op)
      OP_SET: begin
        if (!label_ok(c.group)) begin
          r.sts = STS_RANGE;
        end else begin
          grp_of[c.vertex] = c.group;
          if (!vtx_known[c.vertex]) begin
            vtx_known[c.vertex] = 1'b1;
            known_vtx.insert(known_vtx.size(), c.vertex);
          end
        end
      end
      OP_ADD: begin
        // labels are not range checked here, a shrink keeps old cells counting
        cell_ix = {grp_of[c.vertex], grp_of[c.neighbour]};
        if (cell_cnt[cell_ix] == '1 || entry_cnt == '1) begin
          r.sts = STS_SAT;
        end else begin
          cell_cnt[cell_ix] = cell_cnt[cell_ix] + 1'b1;
          entry_cnt = entry_cnt + 1'b1;
        end
      end
      OP_READ: begin
        if (!label_ok(c.row_g) || !label_ok(c.col_g)) begin
          r.sts = STS_RANGE;
        end else begin
          r.raw  = cell_cnt[{c.row_g, c.col_g}];
          r.half = cell_cnt[{c.col_g, c.row_g}][CNT_W-1:1];
        end
      end
      default: begin
        foreach (cell_cnt[i]) cell_cnt[i] = '0;
        entry_cnt = '0;
      end
    endcase
    r.total = entry_cnt[CNT_W-1:1];
    return r;
  endfunction

  function automatic logic [GRP_W-1:0] pick_label();
    int lim;
    lim = (ng_reg > NG_W'(NGRP)) ? NGRP : int'(ng_reg);
    if (lim > 0 && $urandom_range(99) < 85) return GRP_W'($urandom_range(lim - 1));
    return GRP_W'($urandom_range(NGRP - 1));
  endfunction

  // mostly well-formed traffic: adds only between labeled vertices
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int pick;
    c.op        = OP_SET;
    c.vertex    = VTX_W'($urandom);
    c.neighbour = VTX_W'($urandom);
    c.group     = GRP_W'($urandom);
    c.row_g     = GRP_W'($urandom);
    c.col_g     = GRP_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 20 || known_vtx.size() == 0) begin
      c.op    = OP_SET;
      c.group = pick_label();
    end else if (pick < 62) begin
      c.op        = OP_ADD;
      c.vertex    = known_vtx[$urandom_range(known_vtx.size() - 1)];
      c.neighbour = known_vtx[$urandom_range(known_vtx.size() - 1)];
    end else if (pick < 97) begin
      c.op    = OP_READ;
      c.row_g = pick_label();
      c.col_g = pick_label();
    end else begin
      c.op = OP_CLEAR;
    end
    return c;
  endfunction

  function automatic void add_row(row_kind_t k, op_t op, int v, int n, int g, int r, int c,
                                  status_t s = STS_OK);
    drow_t d;
    d.kind          = k;
    d.cmd.op        = op;
    d.cmd.vertex    = VTX_W'(v);
    d.cmd.neighbour = VTX_W'(n);
    d.cmd.group     = GRP_W'(g);
    d.cmd.row_g     = GRP_W'(r);
    d.cmd.col_g     = GRP_W'(c);
    d.res           = '0;
    d.res.sts       = s;
    d.ng            = '0;
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  function automatic void add_cfg_row(int ng);
    drow_t d;
    d.kind = ROW_CFG;
    d.cmd  = '0;
    d.res  = '0;
    d.ng   = NG_W'(ng);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  task automatic send_cmd(cmd_t c, bit fixed = 1'b0, res_t fixed_res = '0);
    res_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_op        <= c.op;
    in_vertex    <= c.vertex;
    in_neighbour <= c.neighbour;
    in_group     <= c.group;
    in_row_group <= c.row_g;
    in_col_group <= c.col_g;
    do @(posedge clk); while (busy);
    pred = tally_item(c);
    due_results.insert(due_results.size(), fixed ? fixed_res : pred);
  endtask

  task automatic write_ng(logic [NG_W-1:0] v);
    start <= 1'b0;
    while (due_results.size() != 0 || busy) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ng_reg = v;
  endtask

  task automatic cmp_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (due_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, %s %0d half %0d total %0d status %0d",
                 $time, "got raw", out_raw_count, out_half_count, out_edge_total,
                 out_status);
        err_cnt++;
      end else begin
        want = due_results.pop_front();
        cmp_field("raw_count", want.raw, out_raw_count);
        cmp_field("half_count", CNT_W'(want.half), CNT_W'(out_half_count));
        cmp_field("edge_total", CNT_W'(want.total), CNT_W'(out_edge_total));
        cmp_field("status", CNT_W'(want.sts), CNT_W'(out_status));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [NG_W-1:0] extreme_ng [3];
    int ng_pick;
    extreme_ng[0] = NG_W'(16);
    extreme_ng[1] = NG_W'(1);
    extreme_ng[2] = NG_W'(31);

    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    start        <= 1'b0;
    in_op        <= '0;
    in_vertex    <= '0;
    in_neighbour <= '0;
    in_group     <= '0;
    in_row_group <= '0;
    in_col_group <= '0;
    foreach (cell_cnt[i]) cell_cnt[i] = '0;
    foreach (vtx_known[i]) vtx_known[i] = 1'b0;
    entry_cnt = '0;
    ng_reg    = NUM_GROUPS_RST;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset state and range errors at the default group count
    add_row(ROW_FIXED,   OP_READ,  0, 0, 0, 0, 0, STS_OK);
    add_row(ROW_FIXED,   OP_READ,  0, 0, 0, 2, 0, STS_RANGE);
    add_row(ROW_FIXED,   OP_READ,  0, 0, 0, 0, 15, STS_RANGE);
    add_row(ROW_FIXED,   OP_SET,   0, 1023, 0, 15, 15, STS_OK);
    add_row(ROW_FIXED,   OP_SET,   1023, 0, 1, 0, 0, STS_OK);
    add_row(ROW_FIXED,   OP_SET,   5, 0, 2, 0, 0, STS_RANGE);
    add_row(ROW_FIXED,   OP_SET,   682, 341, 15, 0, 0, STS_RANGE);
    add_cfg_row(16);
    add_row(ROW_PREDICT, OP_SET,   5, 0, 15, 0, 0);
    add_row(ROW_PREDICT, OP_SET,   682, 0, 10, 0, 0);
    add_row(ROW_PREDICT, OP_SET,   341, 0, 5, 0, 0);
    add_row(ROW_PREDICT, OP_ADD,   0, 1023, 15, 15, 15);
    add_row(ROW_PREDICT, OP_ADD,   1023, 0, 0, 0, 0);
    add_row(ROW_PREDICT, OP_ADD,   5, 5, 0, 0, 0);
    add_row(ROW_PREDICT, OP_ADD,   682, 341, 0, 0, 0);
    add_row(ROW_PREDICT, OP_READ,  0, 0, 0, 1, 0);
    add_row(ROW_PREDICT, OP_READ,  1023, 1023, 15, 15, 15);
    add_row(ROW_PREDICT, OP_READ,  0, 0, 0, 5, 10);
    // shrink: stored labels above the new limit still count on add
    add_cfg_row(1);
    add_row(ROW_PREDICT, OP_ADD,   682, 5, 0, 0, 0);
    add_row(ROW_PREDICT, OP_READ,  0, 0, 0, 0, 0);
    add_row(ROW_PREDICT, OP_READ,  0, 0, 0, 0, 1);
    add_row(ROW_PREDICT, OP_SET,   7, 0, 1, 0, 0);
    add_cfg_row(0);
    add_row(ROW_PREDICT, OP_READ,  0, 0, 0, 0, 0);
    add_row(ROW_PREDICT, OP_SET,   7, 0, 0, 0, 0);
    add_row(ROW_PREDICT, OP_ADD,   0, 0, 0, 0, 0);
    // above the group maximum acts as the maximum
    add_cfg_row(31);
    add_row(ROW_PREDICT, OP_READ,  0, 0, 0, 10, 15);
    add_row(ROW_FIXED,   OP_CLEAR, 1023, 1023, 15, 15, 15, STS_OK);
    add_row(ROW_FIXED,   OP_READ,  0, 0, 0, 15, 15, STS_OK);

    idle_pct = 32;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) write_ng(dir_rows[i].ng);
      else send_cmd(dir_rows[i].cmd, dir_rows[i].kind == ROW_FIXED, dir_rows[i].res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 32 : (ph == 1) ? 48 : 0;
      for (int chunk = 0; chunk < 4; chunk++) begin
        if (chunk == 0) begin
          write_ng(extreme_ng[ph]);
        end else begin
          ng_pick = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(16, 1);
          write_ng(NG_W'(ng_pick));
        end
        for (int k = 0; k < N_RAND / 12; k++) send_cmd(rand_cmd());
      end
    end

    start <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
